// ===== hw/rtl/uerm_pkg.sv =====
`default_nettype none

package uerm_pkg;

    // Measurement and arithmetic widths
    localparam int COUNT_WIDTH = 32;
    localparam int DIV_WIDTH   = 20;
    localparam int DIST_WIDTH  = 8;
    localparam int QUO_WIDTH   = 16;
    localparam int PROD_WIDTH  = COUNT_WIDTH + 7;          // count * 100 fits in 7 more bits
    localparam int HI_WIDTH    = PROD_WIDTH - QUO_WIDTH;
    localparam int SUB_WIDTH   = (HI_WIDTH > DIV_WIDTH + 1) ? HI_WIDTH : DIV_WIDTH + 1;
    localparam int STEP_WIDTH  = $clog2(QUO_WIDTH);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [QUO_WIDTH-1:0]   QUO_SAT   = {QUO_WIDTH{1'b1}};

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = DIV_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIVISOR   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_VALID = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_VALID = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR_THR   = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR_VALUE = 3'd4;

    localparam logic [DIV_WIDTH-1:0]  RST_DIVISOR   = 20'd93295;
    localparam logic [DIST_WIDTH-1:0] RST_MIN_VALID = 8'd2;
    localparam logic [DIST_WIDTH-1:0] RST_MAX_VALID = 8'd80;
    localparam logic [DIST_WIDTH-1:0] RST_FAR_THR   = 8'd90;
    localparam logic [DIST_WIDTH-1:0] RST_FAR_VALUE = 8'd100;

    typedef struct packed {
        logic [DIV_WIDTH-1:0]  divisor;
        logic [DIST_WIDTH-1:0] min_valid;
        logic [DIST_WIDTH-1:0] max_valid;
        logic [DIST_WIDTH-1:0] far_threshold;
        logic [DIST_WIDTH-1:0] far_value;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic [QUO_WIDTH-1:0] quotient;
    } div_res_t;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_MEAS = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CONV
    } ctl_state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_CMP,
        DV_STEP,
        DV_DONE
    } div_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uerm_regs.sv =====
`default_nettype none

module uerm_regs (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [uerm_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  wire  [uerm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output uerm_pkg::cfg_t                       cfg
);
    import uerm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.divisor       <= RST_DIVISOR;
            cfg_reg.min_valid     <= RST_MIN_VALID;
            cfg_reg.max_valid     <= RST_MAX_VALID;
            cfg_reg.far_threshold <= RST_FAR_THR;
            cfg_reg.far_value     <= RST_FAR_VALUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIVISOR:   cfg_reg.divisor       <= cfg_data;
                REG_MIN_VALID: cfg_reg.min_valid     <= cfg_data[DIST_WIDTH-1:0];
                REG_MAX_VALID: cfg_reg.max_valid     <= cfg_data[DIST_WIDTH-1:0];
                REG_FAR_THR:   cfg_reg.far_threshold <= cfg_data[DIST_WIDTH-1:0];
                REG_FAR_VALUE: cfg_reg.far_value     <= cfg_data[DIST_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/uerm_div.sv =====
`default_nettype none

// Saturating floor(count*100/divisor), one shared subtractor,
// restoring long division one quotient bit per cycle.
module uerm_div (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire  [uerm_pkg::COUNT_WIDTH-1:0]   count,
    input  wire  [uerm_pkg::DIV_WIDTH-1:0]     divisor,
    output uerm_pkg::div_res_t                 res
);
    import uerm_pkg::*;

    div_state_t              state_reg, state_next;
    logic [PROD_WIDTH-1:0]   prod_reg,  prod_next;
    logic [SUB_WIDTH-1:0]    rem_reg,   rem_next;
    logic [QUO_WIDTH-1:0]    quo_reg,   quo_next;
    logic [STEP_WIDTH-1:0]   step_reg,  step_next;

    logic [PROD_WIDTH-1:0]   cnt_ext;
    logic [SUB_WIDTH-1:0]    sub_a;
    logic [SUB_WIDTH:0]      diff;
    logic                    borrow;

    assign cnt_ext = PROD_WIDTH'(prod_reg[COUNT_WIDTH-1:0]);

    // shared subtractor
    assign diff   = {1'b0, sub_a} - {1'b0, SUB_WIDTH'(divisor)};
    assign borrow = diff[SUB_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        sub_a      = '0;
        res.done   = 1'b0;
        res.quotient = quo_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    prod_next  = PROD_WIDTH'(count);
                    state_next = DV_MUL;
                end
            end
            DV_MUL:
            begin
                // x100 = x64 + x32 + x4
                prod_next  = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
                state_next = DV_CMP;
            end
            DV_CMP:
            begin
                // quotient overflows 16 bits iff upper part >= divisor
                sub_a = SUB_WIDTH'(prod_reg[PROD_WIDTH-1:QUO_WIDTH]);
                if (!borrow)
                begin
                    quo_next   = QUO_SAT;
                    state_next = DV_DONE;
                end
                else
                begin
                    rem_next   = sub_a;
                    step_next  = STEP_WIDTH'(QUO_WIDTH - 1);
                    state_next = DV_STEP;
                end
            end
            DV_STEP:
            begin
                sub_a     = {rem_reg[SUB_WIDTH-2:0], prod_reg[QUO_WIDTH-1]};
                prod_next = prod_reg << 1;
                rem_next  = borrow ? sub_a : diff[SUB_WIDTH-1:0];
                quo_next  = {quo_reg[QUO_WIDTH-2:0], ~borrow};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                res.done   = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_range_meter.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   echo_level, read_request
// out       source     out_valid / out_stall distance, updated, phase_out
// cfg       sink       cfg_we                cfg_index, cfg_data
//
// A tick without a conversion has its result registered at accept.
// A tick that converts a finished measurement passes through accept, product, range
// check, 16 restoring steps in the shared subtractor of uerm_div, done and result
// write; the steps are skipped when the quotient saturates.
// rst_n clears control state and loads the configuration defaults.
// in_stall is high while a conversion runs or the output register is full and stalled.
module ultrasonic_echo_range_meter (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   echo_level,
    input  wire                                   read_request,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic [uerm_pkg::DIST_WIDTH-1:0]       distance,
    output logic                                  updated,
    output logic [1:0]                            phase_out,
    input  wire                                   cfg_we,
    input  wire  [uerm_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  wire  [uerm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import uerm_pkg::*;

    cfg_t                     cfg;
    div_res_t                 div_res;

    ctl_state_t               state_reg,     state_next;
    phase_t                   phase_reg,     phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg,     count_next;
    logic                     last_echo_reg, last_echo_next;
    logic [DIST_WIDTH-1:0]    held_reg,      held_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DIST_WIDTH-1:0]    dist_reg,      dist_next;
    logic                     upd_reg,       upd_next;
    logic [1:0]               ph_out_reg,    ph_out_next;

    logic                     out_free;
    logic                     accept;
    logic                     div_start;
    phase_t                   ph_tick;
    logic [COUNT_WIDTH-1:0]   cnt_tick;
    logic [QUO_WIDTH-1:0]     q;

    uerm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uerm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .count   (cnt_tick),
        .divisor (cfg.divisor),
        .res     (div_res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign q        = div_res.quotient;

    // echo edge handling for the tick on the input
    always_comb
    begin
        ph_tick  = phase_reg;
        cnt_tick = count_reg;
        case (phase_reg)
            PH_WAIT:
            begin
                if (echo_level && !last_echo_reg)
                begin
                    cnt_tick = '0;
                    ph_tick  = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                if (count_reg != COUNT_MAX)
                begin
                    cnt_tick = count_reg + 1'b1;
                end
                if (!echo_level && last_echo_reg)
                begin
                    ph_tick = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAIT;
            count_reg     <= '0;
            last_echo_reg <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            last_echo_reg <= last_echo_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        upd_reg    <= upd_next;
        ph_out_reg <= ph_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        last_echo_next = last_echo_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_next      = dist_reg;
        upd_next       = upd_reg;
        ph_out_next    = ph_out_reg;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next     = cnt_tick;
                    last_echo_next = echo_level;
                    if (read_request && (ph_tick == PH_DONE))
                    begin
                        phase_next = PH_WAIT;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        phase_next     = ph_tick;
                        out_valid_next = 1'b1;
                        dist_next      = held_reg;
                        upd_next       = 1'b0;
                        ph_out_next    = ph_tick;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (out_free)
                begin
                    if ((q >= QUO_WIDTH'(cfg.min_valid)) && (q <= QUO_WIDTH'(cfg.max_valid)))
                    begin
                        held_next = q[DIST_WIDTH-1:0];
                    end
                    else if (q > QUO_WIDTH'(cfg.far_threshold))
                    begin
                        held_next = cfg.far_value;
                    end
                    out_valid_next = 1'b1;
                    dist_next      = held_next;
                    upd_next       = 1'b1;
                    ph_out_next    = PH_WAIT;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign updated   = upd_reg;
    assign phase_out = ph_out_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    import uerm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [DIST_WIDTH-1:0] distance;
        logic                  updated;
        phase_t                phase;
    } reading_t;

    class range_scoreboard;
        cfg_t                   regs;
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] echo_ticks;
        logic                   last_echo;
        logic [DIST_WIDTH-1:0]  held;
        reading_t               due[$];
        int                     errors;
        int                     conversions;
        int                     ticks_noted;
        int                     beats_checked;

        function new();
            regs.divisor       = RST_DIVISOR;
            regs.min_valid     = RST_MIN_VALID;
            regs.max_valid     = RST_MAX_VALID;
            regs.far_threshold = RST_FAR_THR;
            regs.far_value     = RST_FAR_VALUE;
            phase              = PH_WAIT;
            echo_ticks         = '0;
            last_echo          = 1'b0;
            held               = '0;
            errors             = 0;
            conversions        = 0;
            ticks_noted        = 0;
            beats_checked      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                REG_DIVISOR:   regs.divisor       = value;
                REG_MIN_VALID: regs.min_valid     = value[DIST_WIDTH-1:0];
                REG_MAX_VALID: regs.max_valid     = value[DIST_WIDTH-1:0];
                REG_FAR_THR:   regs.far_threshold = value[DIST_WIDTH-1:0];
                REG_FAR_VALUE: regs.far_value     = value[DIST_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // floor(count * 100 / divisor), clipped to 16 bits; zero divisor reads as full scale
        function longint unsigned range_quotient(logic [COUNT_WIDTH-1:0] count);
            longint unsigned prod;
            longint unsigned div;
            longint unsigned q;
            if (regs.divisor == '0)
                return 65535;
            prod = count;
            prod = prod * 100;
            div  = regs.divisor;
            q    = prod / div;
            return (q > 65535) ? 65535 : q;
        endfunction

        function void note_tick(logic echo, logic req);
            reading_t        r;
            longint unsigned q;
            r.updated = 1'b0;
            case (phase)
                PH_WAIT:
                begin
                    if (echo && !last_echo)
                    begin
                        echo_ticks = '0;
                        phase      = PH_MEAS;
                    end
                end
                PH_MEAS:
                begin
                    if (echo_ticks != COUNT_MAX)
                        echo_ticks = echo_ticks + 1'b1;
                    if (!echo && last_echo)
                        phase = PH_DONE;
                end
                default: ;
            endcase
            last_echo = echo;
            // edges first, then the read: a fall with a read converts at once
            if (req && phase == PH_DONE)
            begin
                q = range_quotient(echo_ticks);
                if (q >= regs.min_valid && q <= regs.max_valid)
                    held = q[DIST_WIDTH-1:0];
                else if (q > regs.far_threshold)
                    held = regs.far_value;
                phase     = PH_WAIT;
                r.updated = 1'b1;
                conversions++;
            end
            r.distance = held;
            r.phase    = phase;
            due.push_back(r);
            ticks_noted++;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH beat %0d: %s", beats_checked, what);
            errors++;
        endtask

        task check_reading(logic [DIST_WIDTH-1:0] d, logic u, logic [1:0] ph);
            reading_t r;
            beats_checked++;
            if (due.size() == 0)
            begin
                report_mismatch($sformatf("reading with nothing due (distance %0d)", d));
                return;
            end
            r = due.pop_front();
            if (d !== r.distance)
                report_mismatch($sformatf("distance %0d, want %0d", d, r.distance));
            if (u !== r.updated)
                report_mismatch($sformatf("updated %b, want %b", u, r.updated));
            if (ph !== r.phase)
                report_mismatch($sformatf("phase_out %0d, want %0d", ph, r.phase));
        endtask
    endclass

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic                      echo_level   = 1'b0;
    logic                      read_request = 1'b0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [DIST_WIDTH-1:0]     distance;
    logic                      updated;
    logic [1:0]                phase_out;
    logic                      cfg_we       = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index    = REG_DIVISOR;
    logic [CFG_DATA_WIDTH-1:0] cfg_data     = '0;

    range_scoreboard sb;
    bit              steady   = 1'b0;
    int              settings = 0;
    int              cycle_count;

    ultrasonic_echo_range_meter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .echo_level   (echo_level),
        .read_request (read_request),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .updated      (updated),
        .phase_out    (phase_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_tick(input logic echo, input logic req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        echo_level   <= echo;
        read_request <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_tick(echo, req);
    endtask

    task automatic drain_readings();
        in_valid <= 1'b0;
        while (sb.due.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input logic [DIV_WIDTH-1:0] div, input logic [DIST_WIDTH-1:0] lo,
                             input logic [DIST_WIDTH-1:0] hi, input logic [DIST_WIDTH-1:0] far,
                             input logic [DIST_WIDTH-1:0] far_dist);
        write_reg(REG_DIVISOR, div);
        write_reg(REG_MIN_VALID, CFG_DATA_WIDTH'(lo));
        write_reg(REG_MAX_VALID, CFG_DATA_WIDTH'(hi));
        write_reg(REG_FAR_THR, CFG_DATA_WIDTH'(far));
        write_reg(REG_FAR_VALUE, CFG_DATA_WIDTH'(far_dist));
        cfg_we <= 1'b0;
        settings++;
    endtask

    // low lead-in, a high pulse of high_len ticks (rise tick included), then the read
    task automatic echo_pulse(input int high_len, input bit read_at_fall);
        repeat ($urandom_range(1, 3)) send_tick(1'b0, $urandom_range(0, 4) == 0);
        send_tick(1'b1, $urandom_range(0, 3) == 0);
        repeat (high_len - 1) send_tick(1'b1, $urandom_range(0, 3) == 0);
        send_tick(1'b0, read_at_fall);
        if (!read_at_fall)
        begin
            // edges here are ignored until the read re-arms
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)), 1'b0);
            send_tick(1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    task automatic random_traffic(input int n);
        int stop;
        int len;
        stop = sb.ticks_noted + n;
        while (sb.ticks_noted < stop)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 120)
                                                  : $urandom_range(1, 30);
                echo_pulse(len, 1'($urandom_range(0, 1)));
            end
            else
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [DIV_WIDTH-1:0] div, input logic [DIST_WIDTH-1:0] lo,
                             input logic [DIST_WIDTH-1:0] hi, input logic [DIST_WIDTH-1:0] far,
                             input logic [DIST_WIDTH-1:0] far_dist, input int n);
        drain_readings();
        configure(div, lo, hi, far, far_dist);
        steady = ($urandom_range(0, 3) == 0);
        random_traffic(n);
    endtask

    initial
    begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = steady ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_reading(distance, updated, phase_out);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d readings still due", cycle_count, sb.due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // divisor 100 makes the distance equal the tick count
        configure(20'd100, 8'd2, 8'd80, 8'd90, 8'd100);
        send_tick(1'b0, 1'b1);   // read while waiting: ignored
        send_tick(1'b1, 1'b0);   // rise
        send_tick(1'b1, 1'b1);   // read while measuring: ignored
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);   // fall and read on the same tick
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);   // done, count 1
        send_tick(1'b1, 1'b0);   // edges while done are ignored
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);   // below min_valid: held value kept
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);   // read with echo high: no rise after re-arm
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);   // exactly min_valid
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);

        run_phase(RST_DIVISOR, RST_MIN_VALID, RST_MAX_VALID, RST_FAR_THR, RST_FAR_VALUE, 30);
        run_phase(20'd25, 8'd0, 8'd255, 8'd255, 8'd0, 50);
        run_phase(20'd40, 8'd255, 8'd0, 8'd0, 8'd255, 40);      // empty valid range
        run_phase(20'd1, 8'd10, 8'd200, 8'd100, 8'd77, 30);
        run_phase(20'hFFFFF, 8'd0, 8'd0, 8'd0, 8'd200, 30);
        run_phase(20'd0, 8'd5, 8'd50, 8'd254, 8'd9, 25);          // zero divisor
        run_phase(DIV_WIDTH'($urandom_range(20, 400)), DIST_WIDTH'($urandom_range(0, 255)),
                  DIST_WIDTH'($urandom_range(0, 255)), DIST_WIDTH'($urandom_range(0, 255)),
                  DIST_WIDTH'($urandom_range(0, 255)), 50);
        run_phase(DIV_WIDTH'($urandom_range(20, 400)), DIST_WIDTH'($urandom_range(0, 255)),
                  DIST_WIDTH'($urandom_range(0, 255)), DIST_WIDTH'($urandom_range(0, 255)),
                  DIST_WIDTH'($urandom_range(0, 255)), 50);
        run_phase(20'd300, 8'd0, 8'd255, 8'd128, 8'd255, 40);
        run_phase(20'd100, 8'd2, 8'd80, 8'd90, 8'd100, 50);

        drain_readings();
        repeat (30) @(posedge clk);

        $display("checked %0d ticks, %0d conversions, over %0d register settings",
                 sb.ticks_noted, sb.conversions, settings);
        $display("covered zero and full-scale divisors, empty ranges and quotient clipping");
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== ultrasonic_echo_range_meter.f =====
hw/rtl/uerm_pkg.sv
hw/rtl/uerm_regs.sv
hw/rtl/uerm_div.sv
hw/rtl/ultrasonic_echo_range_meter.sv
tb/tb_top.sv
